FILE: rtl/b64d_pkg.sv
`timescale 1ns / 1ps

package b64d_pkg;

   // padding character and the code for a character outside the alphabet
   localparam logic [7:0] PAD_CHAR  = 8'h3D;
   localparam logic [7:0] NO_SYMBOL = 8'h80;

   // status codes reported on the closing word of a text
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FORMAT  = 2'd1,
      STATUS_PADDING = 2'd2
   } status_type;

   // work handed from the front end to the back end for one character
   typedef struct packed {
      logic [23:0] group_bits;
      logic [1:0]  byte_count;
      logic        status_en;
      status_type  status;
   } task_type;

   localparam int TASK_BITS = $bits(task_type);

   // alphabet lookup: six-bit value, zero for the pad, NO_SYMBOL otherwise
   function automatic logic [7:0] symbol_value(input logic [7:0] c);
      logic [7:0] v;
      v = NO_SYMBOL;
      if (c >= 8'h41 && c <= 8'h5A) v = c - 8'h41;
      else if (c >= 8'h61 && c <= 8'h7A) v = c - 8'h61 + 8'd26;
      else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30 + 8'd52;
      else if (c == 8'h2B) v = 8'd62;
      else if (c == 8'h2F) v = 8'd63;
      else if (c == PAD_CHAR) v = 8'd0;
      return v;
   endfunction

endpackage

FILE: rtl/b64d_front.sv
`timescale 1ns / 1ps

module b64d_front #(
   parameter int LENGTH_BITS = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             char_code,
   input  logic                   end_of_text,
   output logic                   task_valid,
   output b64d_pkg::task_type     task_word,
   output logic [LENGTH_BITS-1:0] task_length
);
   import b64d_pkg::*;

   logic [17:0]            held_ff, held_in;
   logic [1:0]             phase_ff, phase_in;
   logic                   any_ff, any_in;
   logic [1:0]             pad_ff, pad_in;
   logic                   fin_ff, fin_in;
   logic                   perr_ff, perr_in;
   logic [LENGTH_BITS-1:0] total_ff, total_in;

   logic [7:0]             sym;
   logic                   sym_ok;
   logic                   is_pad;
   logic [1:0]             pad_tmp;
   logic [1:0]             nb;
   logic [LENGTH_BITS:0]   total_sum;

   // character classification and group assembly
   always_comb begin
      sym       = symbol_value(char_code);
      sym_ok    = (sym != NO_SYMBOL);
      is_pad    = (char_code == PAD_CHAR);
      held_in   = held_ff;
      phase_in  = phase_ff;
      any_in    = any_ff;
      pad_in    = pad_ff;
      fin_in    = fin_ff;
      perr_in   = perr_ff;
      pad_tmp   = pad_ff;
      nb        = 2'd0;
      task_word = '0;
      if (sym_ok) begin
         any_in = 1'b1;
         if (!fin_ff) begin
            if (is_pad && pad_ff != 2'd3) pad_tmp = pad_ff + 2'd1;
            pad_in = pad_tmp;
            if (phase_ff != 2'd3) begin
               held_in = {held_ff[11:0], sym[5:0]};
            end else begin
               task_word.group_bits = {held_ff, sym[5:0]};
               if (pad_tmp == 2'd3) perr_in = 1'b1;
               else nb = 2'd3 - pad_tmp;
               if (pad_tmp != 2'd0) fin_in = 1'b1;
               held_in = '0;
               pad_in  = '0;
            end
         end
         phase_in = phase_ff + 2'd1;
      end
      task_word.byte_count = nb;

      // saturating byte count
      total_sum = {1'b0, total_ff} + (LENGTH_BITS+1)'(nb);
      if (total_sum[LENGTH_BITS]) total_in = '1;
      else total_in = total_sum[LENGTH_BITS-1:0];
      task_length = total_in;

      // closing status, then back to the start of a new text
      if (end_of_text) begin
         task_word.status_en = 1'b1;
         if (!any_in || phase_in != 2'd0) task_word.status = STATUS_FORMAT;
         else if (perr_in) task_word.status = STATUS_PADDING;
         else task_word.status = STATUS_OK;
         held_in  = '0;
         phase_in = '0;
         any_in   = 1'b0;
         pad_in   = '0;
         fin_in   = 1'b0;
         perr_in  = 1'b0;
         total_in = '0;
      end
      task_valid = (nb != 2'd0) || end_of_text;
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         phase_ff <= '0;
         any_ff   <= 1'b0;
         pad_ff   <= '0;
         fin_ff   <= 1'b0;
         perr_ff  <= 1'b0;
         total_ff <= '0;
      end else if (accept) begin
         held_ff  <= held_in;
         phase_ff <= phase_in;
         any_ff   <= any_in;
         pad_ff   <= pad_in;
         fin_ff   <= fin_in;
         perr_ff  <= perr_in;
         total_ff <= total_in;
      end
   end

endmodule

FILE: rtl/b64d_queue.sv
`timescale 1ns / 1ps

module b64d_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             is_full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             is_empty
);
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    store_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_wr;
   logic                do_rd;

   assign is_full  = (count_ff == CNT_BITS'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign do_wr    = wr_en && !is_full;
   assign do_rd    = rd_en && !is_empty;
   assign rd_data  = store_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) count_in = count_ff + 1'b1;
      else if (do_rd && !do_wr) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_wr) store_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

FILE: rtl/b64d_back.sv
`timescale 1ns / 1ps

module b64d_back #(
   parameter int LENGTH_BITS = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  b64d_pkg::task_type     head_task,
   input  logic [LENGTH_BITS-1:0] head_length,
   output logic                   head_pop,
   input  logic                   pop,
   output logic                   empty,
   output logic [7:0]             data_byte,
   output logic                   byte_valid,
   output logic                   status_valid,
   output logic [1:0]             decode_status,
   output logic [LENGTH_BITS-1:0] decoded_length,
   output logic                   run_last
);
   import b64d_pkg::*;

   logic [1:0]             idx_ff, idx_in;
   logic                   out_valid_ff;
   logic [7:0]             data_ff, data_in;
   logic                   bv_ff, bv_in;
   logic                   sv_ff, sv_in;
   logic [1:0]             st_ff, st_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic                   last_ff, last_in;
   logic                   load;

   assign load = head_valid && (!out_valid_ff || pop);

   // build the next word of the head task
   always_comb begin
      data_in = '0;
      bv_in   = 1'b0;
      sv_in   = 1'b0;
      st_in   = '0;
      len_in  = '0;
      last_in = 1'b1;
      if (idx_ff < head_task.byte_count) begin
         bv_in   = 1'b1;
         last_in = (idx_ff == head_task.byte_count - 2'd1) && !head_task.status_en;
         case (idx_ff)
            2'd0:    data_in = head_task.group_bits[23:16];
            2'd1:    data_in = head_task.group_bits[15:8];
            2'd2:    data_in = head_task.group_bits[7:0];
            default: data_in = '0;
         endcase
      end else begin
         sv_in  = 1'b1;
         st_in  = head_task.status;
         len_in = head_length;
      end
      head_pop = load && last_in;
      idx_in   = last_in ? 2'd0 : idx_ff + 2'd1;
   end

   // control state of the output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) idx_ff <= idx_in;
         if (load) out_valid_ff <= 1'b1;
         else if (pop) out_valid_ff <= 1'b0;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         bv_ff   <= bv_in;
         sv_ff   <= sv_in;
         st_ff   <= st_in;
         len_ff  <= len_in;
         last_ff <= last_in;
      end
   end

   assign empty          = !out_valid_ff;
   assign data_byte      = data_ff;
   assign byte_valid     = bv_ff;
   assign status_valid   = sv_ff;
   assign decode_status  = st_ff;
   assign decoded_length = len_ff;
   assign run_last       = last_ff;

endmodule

FILE: rtl/base64_stream_decoder_top.sv
`timescale 1ns / 1ps
// a character's words go through the task queue and then the output word register
// throughput: one character per cycle in while not full, one word per cycle out while popped
// a character closing a group or the text gives a word per byte and status (up to four);
// the task queue of QUEUE_DEPTH entries absorbs bursts between front and back end
// reset: synchronous, active high, clears decoder state, queue and output stage

module base64_stream_decoder_top #(
   parameter int LENGTH_BITS = 20,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [7:0]             req_char_code,
   input  logic                   req_end_of_text,
   output logic                   empty,
   input  logic                   pop,
   output logic [7:0]             rsp_data_byte,
   output logic                   rsp_byte_valid,
   output logic                   rsp_status_valid,
   output logic [1:0]             rsp_decode_status,
   output logic [LENGTH_BITS-1:0] rsp_decoded_length,
   output logic                   rsp_run_last
);
   import b64d_pkg::*;

   localparam int ENTRY_BITS = TASK_BITS + LENGTH_BITS;

   logic                   front_accept;
   logic                   front_valid;
   task_type               front_task;
   logic [LENGTH_BITS-1:0] front_length;
   logic                   q_empty;
   logic                   q_pop;
   logic [ENTRY_BITS-1:0]  q_head;
   task_type               head_task;
   logic [LENGTH_BITS-1:0] head_length;

   assign front_accept = push && !full;

   // front end: classify characters and assemble groups
   b64d_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (front_accept),
      .char_code   (req_char_code),
      .end_of_text (req_end_of_text),
      .task_valid  (front_valid),
      .task_word   (front_task),
      .task_length (front_length)
   );

   // task queue between front and back end
   b64d_queue #(.WIDTH(ENTRY_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (front_accept && front_valid),
      .wr_data  ({front_length, front_task}),
      .is_full  (full),
      .rd_en    (q_pop),
      .rd_data  (q_head),
      .is_empty (q_empty)
   );

   assign head_task   = task_type'(q_head[TASK_BITS-1:0]);
   assign head_length = q_head[TASK_BITS +: LENGTH_BITS];

   // back end: serialize bytes and status into result words
   b64d_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (!q_empty),
      .head_task      (head_task),
      .head_length    (head_length),
      .head_pop       (q_pop),
      .pop            (pop),
      .empty          (empty),
      .data_byte      (rsp_data_byte),
      .byte_valid     (rsp_byte_valid),
      .status_valid   (rsp_status_valid),
      .decode_status  (rsp_decode_status),
      .decoded_length (rsp_decoded_length),
      .run_last       (rsp_run_last)
   );

   // a word is either a byte or a status, never both
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_byte_valid != rsp_status_valid))
      else $error("result word is neither or both of byte and status");

   // the status closes the run of its character
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status_valid) |-> rsp_run_last)
      else $error("status word without run_last");

   // length and status fields are zero on byte words
   a_byte_fields: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_byte_valid) |-> (rsp_decoded_length == '0 && rsp_decode_status == '0))
      else $error("status fields set on a byte word");

   // the queue never pops while it is empty
   a_queue_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("task queue popped while empty");

endmodule

FILE: tb/base64_stream_decoder_top_tb.sv
`timescale 1ns / 1ps

module base64_stream_decoder_top_tb;

   import b64d_pkg::*;

   localparam int      LEN_BITS        = 20;
   localparam int      TOTAL_ITEMS     = 400;
   localparam int      PRESSURE_AT     = 150;
   localparam int      CALM_AT         = 320;
   localparam int      HOLD_OFF_CYCLES = 300;
   localparam int      DRAIN_CYCLES    = 8;
   localparam longint  LIMIT_NS        = 4_000_000;

   // one result word as the decoder should present it
   typedef struct packed {
      logic [7:0]          data_byte;
      logic                byte_valid;
      logic                status_valid;
      status_type          status;
      logic [LEN_BITS-1:0] length;
      logic                run_last;
   } decoded_word_type;

   // one directed character, with the closing status typed in where obvious
   typedef struct packed {
      logic [7:0]          char_code;
      logic                end_of_text;
      logic                typed;
      status_type          status;
      logic [LEN_BITS-1:0] length;
   } stim_row_type;

   logic                clock;
   logic                reset;
   logic                push;
   logic                full;
   logic [7:0]          req_char_code;
   logic                req_end_of_text;
   logic                empty;
   logic                pop;
   logic [7:0]          rsp_data_byte;
   logic                rsp_byte_valid;
   logic                rsp_status_valid;
   logic [1:0]          rsp_decode_status;
   logic [LEN_BITS-1:0] rsp_decoded_length;
   logic                rsp_run_last;

   // decoder state as predicted
   logic [17:0]         open_group   = '0;
   logic [1:0]          symbol_phase = '0;
   logic                saw_symbol   = 1'b0;
   logic [1:0]          pad_count    = '0;
   logic                text_closed  = 1'b0;
   logic                pad_fault    = 1'b0;
   logic [LEN_BITS-1:0] bytes_sent   = '0;

   decoded_word_type step_words[$];
   decoded_word_type words_due[$];

   int mismatches       = 0;
   int words_checked    = 0;
   int bytes_checked    = 0;
   int status_hits[3]   = '{0, 0, 0};
   int items_sent       = 0;
   int stall_cycles     = 0;
   bit calm             = 1'b0;
   bit hold_off_request = 1'b0;
   bit pressure_done    = 1'b0;

   // extremes, every pad count, symbols after padding and the status order
   stim_row_type directed_rows [25] = '{
      '{8'hFF, 1'b1, 1'b1, STATUS_FORMAT,  20'd0},
      '{8'h2F, 1'b0, 1'b0, STATUS_OK,      20'd0},
      '{8'h2F, 1'b0, 1'b0, STATUS_OK,      20'd0},
      '{8'h2B, 1'b0, 1'b0, STATUS_OK,      20'd0},
      '{8'h2F, 1'b0, 1'b0, STATUS_OK,      20'd0},
      '{8'h51, 1'b0, 1'b0, STATUS_OK,      20'd0},
      '{8'h55, 1'b0, 1'b0, STATUS_OK,      20'd0},
      '{8'h45, 1'b0, 1'b0, STATUS_OK,      20'd0},
      '{8'h3D, 1'b1, 1'b1, STATUS_OK,      20'd5},
      '{8'h51, 1'b0, 1'b0, STATUS_OK,      20'd0},
      '{8'h51, 1'b0, 1'b0, STATUS_OK,      20'd0},
      '{8'h3D, 1'b0, 1'b0, STATUS_OK,      20'd0},
      '{8'h3D, 1'b0, 1'b0, STATUS_OK,      20'd0},
      '{8'h41, 1'b0, 1'b0, STATUS_OK,      20'd0},
      '{8'h7A, 1'b0, 1'b0, STATUS_OK,      20'd0},
      '{8'h39, 1'b1, 1'b1, STATUS_FORMAT,  20'd1},
      '{8'h41, 1'b0, 1'b0, STATUS_OK,      20'd0},
      '{8'h3D, 1'b0, 1'b0, STATUS_OK,      20'd0},
      '{8'h3D, 1'b0, 1'b0, STATUS_OK,      20'd0},
      '{8'h3D, 1'b1, 1'b1, STATUS_PADDING, 20'd0},
      '{8'h3D, 1'b0, 1'b0, STATUS_OK,      20'd0},
      '{8'h3D, 1'b0, 1'b0, STATUS_OK,      20'd0},
      '{8'h3D, 1'b0, 1'b0, STATUS_OK,      20'd0},
      '{8'h3D, 1'b0, 1'b0, STATUS_OK,      20'd0},
      '{8'h42, 1'b1, 1'b1, STATUS_FORMAT,  20'd0}
   };

   base64_stream_decoder_top #(
      .LENGTH_BITS(LEN_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_char_code(req_char_code),
      .req_end_of_text(req_end_of_text),
      .empty(empty),
      .pop(pop),
      .rsp_data_byte(rsp_data_byte),
      .rsp_byte_valid(rsp_byte_valid),
      .rsp_status_valid(rsp_status_valid),
      .rsp_decode_status(rsp_decode_status),
      .rsp_decoded_length(rsp_decoded_length),
      .rsp_run_last(rsp_run_last)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #(LIMIT_NS);
      $display("Mismatches found");
      $finish;
   end

   // character for a six-bit symbol value
   function automatic logic [7:0] symbol_char(input int idx);
      if (idx < 26) return 8'(8'h41 + idx);
      if (idx < 52) return 8'(8'h61 + idx - 26);
      if (idx < 62) return 8'(8'h30 + idx - 52);
      return (idx == 62) ? 8'h2B : 8'h2F;
   endfunction

   // symbol value of a character, pad counts as zero, -1 when skipped
   function automatic int symbol_of(input logic [7:0] c);
      if (c == PAD_CHAR) return 0;
      for (int i = 0; i < 64; i++) begin
         if (symbol_char(i) == c) return i;
      end
      return -1;
   endfunction

   // random character that the decoder skips
   function automatic logic [7:0] noise_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (symbol_of(c) >= 0);
      return c;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR: %s", msg);
      mismatches++;
   endtask

   task automatic compare_field(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("word %0d %s: got %0h expected %0h",
                                   words_checked, field, got, want));
   endtask

   // predicted words for one character, left in step_words
   task automatic decode_char(input logic [7:0] c, input logic eot);
      int               v;
      logic [23:0]      group;
      decoded_word_type w;
      step_words.delete();
      v = symbol_of(c);
      // symbols and pads advance the open group
      if (v >= 0) begin
         saw_symbol = 1'b1;
         if (!text_closed) begin
            if (c == PAD_CHAR && pad_count != 2'd3) pad_count = pad_count + 2'd1;
            if (symbol_phase != 2'd3) begin
               open_group = {open_group[11:0], 6'(v)};
            end else begin
               group = {open_group, 6'(v)};
               if (pad_count == 2'd3) begin
                  pad_fault = 1'b1;
               end else begin
                  for (int i = 0; i < 3 - pad_count; i++) begin
                     w = '0;
                     w.data_byte = group[23 - 8 * i -: 8];
                     w.byte_valid = 1'b1;
                     step_words.push_back(w);
                     if (bytes_sent != '1) bytes_sent = bytes_sent + 1'b1;
                  end
               end
               if (pad_count != 2'd0) text_closed = 1'b1;
               open_group = '0;
               pad_count = '0;
            end
         end
         symbol_phase = symbol_phase + 2'd1;
      end
      // closing status, then a fresh text
      if (eot) begin
         w = '0;
         w.status_valid = 1'b1;
         if (!saw_symbol || symbol_phase != 2'd0) w.status = STATUS_FORMAT;
         else if (pad_fault) w.status = STATUS_PADDING;
         else w.status = STATUS_OK;
         w.length = bytes_sent;
         step_words.push_back(w);
         open_group = '0;
         symbol_phase = '0;
         saw_symbol = 1'b0;
         pad_count = '0;
         text_closed = 1'b0;
         pad_fault = 1'b0;
         bytes_sent = '0;
      end
      if (step_words.size() > 0) begin
         w = step_words.pop_back();
         w.run_last = 1'b1;
         step_words.push_back(w);
      end
   endtask

   // offer one character until taken, record its words, maybe idle after
   task automatic send_char(input logic [7:0] c, input logic eot, input logic typed,
                            input status_type st, input logic [LEN_BITS-1:0] len);
      int               gap;
      decoded_word_type w;
      push <= 1'b1;
      req_char_code <= c;
      req_end_of_text <= eot;
      do begin
         @(posedge clock);
         if (full) stall_cycles++;
      end while (full);
      decode_char(c, eot);
      if (typed) begin
         w = step_words.pop_back();
         w.status = st;
         w.length = len;
         step_words.push_back(w);
      end
      foreach (step_words[i]) words_due.push_back(step_words[i]);
      items_sent++;
      // idle burst on the input side
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // one random text: mostly well formed groups, some cut, overpadded, with stray pads or noisy
   task automatic send_random_text();
      logic [7:0] text[$];
      logic [7:0] c;
      int         groups;
      int         style;
      int         pads;
      int         cut;
      groups = ($urandom_range(0, 11) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 4);
      style = $urandom_range(0, 11);
      pads = (style == 9) ? $urandom_range(3, 4) : $urandom_range(0, 2);
      for (int g = 0; g < groups; g++) begin
         for (int k = 0; k < 4; k++) begin
            if ($urandom_range(0, (style == 11) ? 1 : 9) == 0) text.push_back(noise_char());
            if (g == groups - 1 && k >= 4 - pads) c = PAD_CHAR;
            else c = symbol_char($urandom_range(0, 63));
            // stray pads in the middle of the text
            if (style == 10 && $urandom_range(0, 5) == 0) c = PAD_CHAR;
            text.push_back(c);
         end
      end
      // text cut short inside a group
      if (style == 8) begin
         cut = $urandom_range(1, 3);
         repeat (cut) begin
            if (text.size() > 0) text.delete(text.size() - 1);
         end
      end
      if (text.size() == 0 || $urandom_range(0, 3) == 0) text.push_back(noise_char());
      foreach (text[i]) send_char(text[i], i == text.size() - 1, 1'b0, STATUS_OK, '0);
   endtask

   // result side: check each word taken, idle in bursts, one long hold-off
   initial begin
      int               idle_left;
      decoded_word_type w;
      idle_left = 0;
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) begin
            if (words_due.size() == 0) begin
               report_mismatch($sformatf("unexpected word %0d: data %0h bv %b sv %b st %0d",
                                         words_checked, rsp_data_byte, rsp_byte_valid,
                                         rsp_status_valid, rsp_decode_status));
            end else begin
               w = words_due.pop_front();
               compare_field("data_byte", 32'(rsp_data_byte), 32'(w.data_byte));
               compare_field("byte_valid", 32'(rsp_byte_valid), 32'(w.byte_valid));
               compare_field("status_valid", 32'(rsp_status_valid), 32'(w.status_valid));
               compare_field("decode_status", 32'(rsp_decode_status), 32'(w.status));
               compare_field("decoded_length", 32'(rsp_decoded_length), 32'(w.length));
               compare_field("run_last", 32'(rsp_run_last), 32'(w.run_last));
               if (w.byte_valid) bytes_checked++;
               if (w.status_valid) status_hits[w.status]++;
            end
            words_checked++;
         end
         if (reset) begin
            pop <= 1'b0;
         end else begin
            if (hold_off_request) begin
               hold_off_request = 1'b0;
               idle_left = HOLD_OFF_CYCLES;
            end else if (idle_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
               idle_left = $urandom_range(1, 7);
            end
            if (idle_left > 0) begin
               idle_left--;
               pop <= 1'b0;
            end else begin
               pop <= 1'b1;
            end
         end
      end
   end

   // reset, directed table, random texts, drain
   initial begin
      reset <= 1'b1;
      push <= 1'b0;
      req_char_code <= '0;
      req_end_of_text <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_char(directed_rows[i].char_code, directed_rows[i].end_of_text,
                   directed_rows[i].typed, directed_rows[i].status, directed_rows[i].length);

      while (items_sent < TOTAL_ITEMS) begin
         if (items_sent >= PRESSURE_AT && !pressure_done) begin
            hold_off_request = 1'b1;
            pressure_done = 1'b1;
         end
         if (items_sent >= CALM_AT) calm = 1'b1;
         send_random_text();
      end
      push <= 1'b0;

      // wait for every predicted word, then a quiet drain before the report
      while (words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d texts, %0d data bytes; status ok/format/padding %0d/%0d/%0d",
               status_hits[0] + status_hits[1] + status_hits[2], bytes_checked,
               status_hits[0], status_hits[1], status_hits[2]);
      $display("input held off by full for %0d cycles, incl. a %0d cycle output stall",
               stall_cycles, HOLD_OFF_CYCLES);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
